### hdl/csfw_pkg.sv
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared types, constants and helpers of the counting semaphore with a
// first-in first-out queue of blocked requesters.
// ----------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

    // queue geometry and field widths
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int UNITS_W     = 32;
    localparam int ID_PORT_W   = 8;

    // request operations
    typedef enum logic [1:0] {
        MD_OPEN   = 2'd0,
        MD_WAIT   = 2'd1,
        MD_SIGNAL = 2'd2,
        MD_CLOSE  = 2'd3
    } t_mode;

    // request status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BLOCKED = 2'd1,
        ST_CLOSED  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    // shared arithmetic unit operations
    typedef enum logic {
        ALU_SUB    = 1'b0,
        ALU_ADDSAT = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [UNITS_W-1:0]   a;
        logic [UNITS_W-1:0]   b;
    } t_alu_req;

    // flag: a >= b for subtract, carry out for add
    typedef struct packed {
        logic [UNITS_W-1:0]   res;
        logic                 flag;
    } t_alu_rsp;

    // queue write port
    typedef struct packed {
        logic                 en;
        logic [QPTR_W-1:0]    addr;
        logic [ID_BITS-1:0]   id;
        logic [UNITS_W-1:0]   demand;
    } t_q_wr;

    // circular pointer advance
    function automatic logic [QPTR_W-1:0] next_slot(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] nxt;
        if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
            nxt = '0;
        end else begin
            nxt = ptr + 1'b1;
        end
        return nxt;
    endfunction

endpackage

`default_nettype wire

### hdl/csfw_alu.sv
// ----------------------------------------------------------------------------
// csfw_alu
// Shared 32-bit adder: compare-and-subtract, or add with saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_alu
    import csfw_pkg::*;
(
    input  wire t_alu_req i_req,
    output t_alu_rsp      o_rsp
);

    logic              is_sub;
    logic [UNITS_W:0]  sum;
    logic [UNITS_W-1:0] b_op;

    // one adder, operand inverted for subtract
    always_comb begin
        is_sub = (i_req.op == ALU_SUB);
        b_op   = is_sub ? ~i_req.b : i_req.b;
        sum    = {1'b0, i_req.a} + {1'b0, b_op} + {{UNITS_W{1'b0}}, is_sub};
    end

    // saturate on add carry
    always_comb begin
        o_rsp.flag = sum[UNITS_W];
        if (!is_sub && sum[UNITS_W]) begin
            o_rsp.res = '1;
        end else begin
            o_rsp.res = sum[UNITS_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/csfw_queue.sv
// ----------------------------------------------------------------------------
// csfw_queue
// Waiter storage: identity and demand per slot, one write port, one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_queue
    import csfw_pkg::*;
(
    input  wire                      i_clk,
    input  wire t_q_wr               i_wr,
    input  wire [QPTR_W-1:0]         i_raddr,
    output logic [ID_BITS-1:0]       o_rd_id,
    output logic [UNITS_W-1:0]       o_rd_demand
);

    logic [ID_BITS-1:0] r_ids     [QUEUE_DEPTH];
    logic [UNITS_W-1:0] r_demands [QUEUE_DEPTH];

    // write at tail
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_ids[i_wr.addr]     <= i_wr.id;
            r_demands[i_wr.addr] <= i_wr.demand;
        end
    end

    // registered read at head
    always_ff @(posedge i_clk) begin
        o_rd_id     <= r_ids[i_raddr];
        o_rd_demand <= r_demands[i_raddr];
    end

endmodule

`default_nettype wire

### hdl/counting_semaphore_fifo_waiters.sv
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore with a queue of blocked requesters, run by a small
// sequencer around one shared adder and a waiter memory.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake               | fields
//  ---------+-----------+-------------------------+-----------------------------
//  request  | in        | i_in_valid / o_in_stall | i_mode i_requester_id i_count
//  result   | out       | o_out_valid/ i_out_stall| o_kind o_woken_id o_wake_code
//           |           |                         | o_status o_last
//
//  open, wait and a signal on a closed semaphore pass the execute and status
//  states only; close and signal then walk the queue with one memory read and
//  one adder pass per waiter until the queue empties or a signal's head blocks.
//  synchronous reset: semaphore closed, zero units, queue empty.
//  a stalled result word holds the sequencer; the next request is taken
//  while the final result word still waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_fifo_waiters
    import csfw_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    input  wire [1:0]             i_mode,
    input  wire [ID_PORT_W-1:0]   i_requester_id,
    input  wire [UNITS_W-1:0]     i_count,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    output logic                  o_kind,
    output logic [ID_PORT_W-1:0]  o_woken_id,
    output logic                  o_wake_code,
    output logic [1:0]            o_status,
    output logic                  o_last
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_RD   = 5'b00100,
        S_CHK  = 5'b01000,
        S_STAT = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    t_mode                r_mode;
    logic [ID_BITS-1:0]   r_id;
    logic [UNITS_W-1:0]   r_count;
    logic [UNITS_W-1:0]   r_units, n_units;
    logic                 r_closed, n_closed;
    logic [QPTR_W-1:0]    r_head, n_head;
    logic [QPTR_W-1:0]    r_tail, n_tail;
    logic [QCNT_W-1:0]    r_qcount, n_qcount;
    t_status              r_status, n_status;

    logic                 r_out_valid, n_out_valid;
    logic                 r_kind, n_kind;
    logic [ID_BITS-1:0]   r_woken_id, n_woken_id;
    logic                 r_code, n_code;
    t_status              r_ostatus, n_ostatus;
    logic                 r_last, n_last;
    logic                 load_out;

    logic                 in_accept;
    logic                 slot_free;
    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    t_q_wr                q_wr;
    logic [ID_BITS-1:0]   q_rd_id;
    logic [UNITS_W-1:0]   q_rd_demand;

    assign in_accept = i_in_valid && !o_in_stall;
    assign slot_free = !r_out_valid || !i_out_stall;

    // shared adder
    csfw_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // waiter memory
    csfw_queue u_queue (
        .i_clk       (i_clk),
        .i_wr        (q_wr),
        .i_raddr     (r_head),
        .o_rd_id     (q_rd_id),
        .o_rd_demand (q_rd_demand)
    );

    // adder operand selection
    always_comb begin
        alu_req.a = r_units;
        if (r_state == S_CHK) begin
            alu_req.op = ALU_SUB;
            alu_req.b  = q_rd_demand;
        end else begin
            alu_req.op = (r_mode == MD_SIGNAL) ? ALU_ADDSAT : ALU_SUB;
            alu_req.b  = r_count;
        end
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_units    = r_units;
        n_closed   = r_closed;
        n_head     = r_head;
        n_tail     = r_tail;
        n_qcount   = r_qcount;
        n_status   = r_status;
        load_out   = 1'b0;
        n_kind     = r_kind;
        n_woken_id = r_woken_id;
        n_code     = r_code;
        n_ostatus  = r_ostatus;
        n_last     = r_last;
        q_wr.en     = 1'b0;
        q_wr.addr   = r_tail;
        q_wr.id     = r_id;
        q_wr.demand = r_count;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_STAT;
                n_status = ST_OK;
                case (r_mode)
                    MD_OPEN: begin
                        n_units  = r_count;
                        n_closed = 1'b0;
                        n_head   = '0;
                        n_tail   = '0;
                        n_qcount = '0;
                    end
                    MD_WAIT: begin
                        if (r_closed) begin
                            n_status = ST_CLOSED;
                        end else if (alu_rsp.flag) begin
                            n_units = alu_rsp.res;
                        end else if (r_qcount == QCNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            q_wr.en  = 1'b1;
                            n_tail   = next_slot(r_tail);
                            n_qcount = r_qcount + 1'b1;
                            n_status = ST_BLOCKED;
                        end
                    end
                    MD_SIGNAL: begin
                        if (r_closed) begin
                            n_status = ST_CLOSED;
                        end else begin
                            n_units = alu_rsp.res;
                            n_state = S_RD;
                        end
                    end
                    MD_CLOSE: begin
                        n_closed = 1'b1;
                        n_state  = S_RD;
                    end
                    default: begin
                        n_state = S_STAT;
                    end
                endcase
            end
            S_RD: begin
                // memory delivers the head entry at the end of this cycle
                if (r_qcount == '0) begin
                    if (r_mode == MD_CLOSE) begin
                        n_head = '0;
                        n_tail = '0;
                    end
                    n_state = S_STAT;
                end else begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_mode == MD_CLOSE || alu_rsp.flag) begin
                    if (slot_free) begin
                        load_out   = 1'b1;
                        n_kind     = 1'b1;
                        n_woken_id = q_rd_id;
                        n_code     = (r_mode == MD_CLOSE);
                        n_ostatus  = ST_OK;
                        n_last     = 1'b0;
                        if (r_mode != MD_CLOSE) begin
                            n_units = alu_rsp.res;
                        end
                        n_head   = next_slot(r_head);
                        n_qcount = r_qcount - 1'b1;
                        n_state  = S_RD;
                    end
                end else begin
                    n_state = S_STAT;
                end
            end
            S_STAT: begin
                if (slot_free) begin
                    load_out   = 1'b1;
                    n_kind     = 1'b0;
                    n_woken_id = '0;
                    n_code     = 1'b0;
                    n_ostatus  = r_status;
                    n_last     = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output word valid
    always_comb begin
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_units     <= '0;
            r_closed    <= 1'b1;
            r_head      <= '0;
            r_tail      <= '0;
            r_qcount    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_units     <= n_units;
            r_closed    <= n_closed;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_qcount    <= n_qcount;
            r_out_valid <= n_out_valid;
        end
    end

    // request word and result payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= t_mode'(i_mode);
            r_id    <= i_requester_id[ID_BITS-1:0];
            r_count <= i_count;
        end
        r_status   <= n_status;
        r_kind     <= n_kind;
        r_woken_id <= n_woken_id;
        r_code     <= n_code;
        r_ostatus  <= n_ostatus;
        r_last     <= n_last;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_woken_id  = ID_PORT_W'(r_woken_id);
    assign o_wake_code = r_code;
    assign o_status    = r_ostatus;
    assign o_last      = r_last;

    // queue occupancy never exceeds its depth
    a_qcount_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcount <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    // an empty queue has head and tail together
    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_qcount == '0) |-> (r_head == r_tail))
        else $error("empty queue with pointers apart");

    // a wakeup word is never the final word of a request
    a_wake_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind) |-> !o_last)
        else $error("wakeup word marked last");

    // a taken request holds off the next one
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_in_stall)
        else $error("request taken while busy");

endmodule

`default_nettype wire

### sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the counting semaphore with its queue of blocked requesters. A
// scoreboard class predicts the status and wakeup words of every accepted
// request, and each result word is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import csfw_pkg::*;

    localparam int RANDOM_ITEMS = 320;
    localparam int QUIET_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;
    localparam int SHOWN_ERRORS = 30;

    // one result word as seen on the output channel
    typedef struct packed {
        logic                 kind;
        logic [ID_PORT_W-1:0] woken_id;
        logic                 wake_code;
        t_status              status;
        logic                 last;
    } sem_word_t;

    // semaphore prediction and ordered comparison of result words
    class sem_scoreboard;
        logic [UNITS_W-1:0]  units;
        logic                closed;
        logic [ID_BITS-1:0]  ids [QUEUE_DEPTH];
        logic [UNITS_W-1:0]  demands [QUEUE_DEPTH];
        logic [QPTR_W-1:0]   head;
        logic [QPTR_W-1:0]   tail;
        int                  waiting;
        sem_word_t           expected_words [$];
        int                  mismatches;

        function new();
            units      = '0;
            closed     = 1'b1;
            head       = '0;
            tail       = '0;
            waiting    = 0;
            mismatches = 0;
            for (int k = 0; k < QUEUE_DEPTH; k++) begin
                ids[k]     = '0;
                demands[k] = '0;
            end
        endfunction

        function logic [QPTR_W-1:0] wrap_inc(logic [QPTR_W-1:0] ptr);
            return (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + 1'b1;
        endfunction

        function void push_word(logic kind, logic [ID_BITS-1:0] who, logic code,
                                t_status st, logic fin);
            sem_word_t w;
            w.kind      = kind;
            w.woken_id  = ID_PORT_W'(who);
            w.wake_code = code;
            w.status    = st;
            w.last      = fin;
            expected_words.push_back(w);
        endfunction

        // wake the head waiter and drop it from the queue
        function void release_head(logic code);
            push_word(1'b1, ids[head], code, ST_OK, 1'b0);
            head    = wrap_inc(head);
            waiting = waiting - 1;
        endfunction

        // predict the words caused by one accepted request
        function void note_request(t_mode mode, logic [ID_PORT_W-1:0] who,
                                   logic [UNITS_W-1:0] n);
            t_status          st;
            logic [UNITS_W:0] sum;
            st = ST_OK;
            case (mode)
                MD_OPEN: begin
                    units   = n;
                    closed  = 1'b0;
                    head    = '0;
                    tail    = '0;
                    waiting = 0;
                end
                MD_WAIT: begin
                    if (closed) begin
                        st = ST_CLOSED;
                    end else if (units >= n) begin
                        units = units - n;
                    end else if (waiting >= QUEUE_DEPTH) begin
                        st = ST_FULL;
                    end else begin
                        ids[tail]     = who[ID_BITS-1:0];
                        demands[tail] = n;
                        tail          = wrap_inc(tail);
                        waiting       = waiting + 1;
                        st            = ST_BLOCKED;
                    end
                end
                MD_SIGNAL: begin
                    if (closed) begin
                        st = ST_CLOSED;
                    end else begin
                        // saturating add, then release heads that fit
                        sum   = {1'b0, units} + {1'b0, n};
                        units = sum[UNITS_W] ? '1 : sum[UNITS_W-1:0];
                        while (waiting > 0 && demands[head] <= units) begin
                            units = units - demands[head];
                            release_head(1'b0);
                        end
                    end
                end
                default: begin
                    closed = 1'b1;
                    while (waiting > 0) begin
                        release_head(1'b1);
                    end
                    head = '0;
                    tail = '0;
                end
            endcase
            push_word(1'b0, '0, 1'b0, st, 1'b1);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("[%0t] mismatch: %s", $time, what);
            end
        endtask

        // compare one accepted result word with the oldest prediction
        task check_word(sem_word_t got);
            sem_word_t exp;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("result word with nothing expected (%p)", got));
                return;
            end
            exp = expected_words.pop_front();
            if (got.kind !== exp.kind)
                report_mismatch($sformatf("kind %b, expected %b", got.kind, exp.kind));
            if (got.woken_id !== exp.woken_id)
                report_mismatch($sformatf("woken_id %0h, expected %0h",
                                          got.woken_id, exp.woken_id));
            if (got.wake_code !== exp.wake_code)
                report_mismatch($sformatf("wake_code %b, expected %b",
                                          got.wake_code, exp.wake_code));
            if (got.status !== exp.status)
                report_mismatch($sformatf("status %0d, expected %0d",
                                          got.status, exp.status));
            if (got.last !== exp.last)
                report_mismatch($sformatf("last %b, expected %b", got.last, exp.last));
        endtask
    endclass

    logic                 i_clk          = 1'b0;
    logic                 i_rst_n        = 1'b0;
    logic                 i_in_valid     = 1'b0;
    logic                 o_in_stall;
    logic [1:0]           i_mode         = MD_OPEN;
    logic [ID_PORT_W-1:0] i_requester_id = '0;
    logic [UNITS_W-1:0]   i_count        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall    = 1'b0;
    logic                 o_kind;
    logic [ID_PORT_W-1:0] o_woken_id;
    logic                 o_wake_code;
    logic [1:0]           o_status;
    logic                 o_last;

    sem_scoreboard board;
    bit            sender_calm = 1'b0;
    bit            sink_calm   = 1'b0;
    int            stall_left  = 0;
    int            sink_cycle  = 0;

    counting_semaphore_fifo_waiters dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_requester_id (i_requester_id),
        .i_count        (i_count),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_woken_id     (o_woken_id),
        .o_wake_code    (o_wake_code),
        .o_status       (o_status),
        .o_last         (o_last)
    );

    // clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // idle length: mostly short, a few long
    function automatic int idle_span();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // unit counts: mostly small so that waits block and signals release
    function automatic logic [UNITS_W-1:0] pick_units();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 12);
        if (r < 92) return $urandom;
        return '1;
    endfunction

    // monitor: check result words, then note accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                board.check_word({o_kind, o_woken_id, o_wake_code,
                                  t_status'(o_status), o_last});
            end
            if (i_in_valid && !o_in_stall) begin
                board.note_request(t_mode'(i_mode), i_requester_id, i_count);
            end
        end
    end

    // result sink stalls, with calm stretches now and then
    always @(posedge i_clk) begin
        sink_cycle <= sink_cycle + 1;
        if (sink_cycle % 256 == 0) begin
            sink_calm <= ($urandom_range(0, 3) == 0);
        end
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!sink_calm && $urandom_range(0, 3) == 0) begin
            stall_left  <= idle_span() - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // drive one request word and hold it until taken
    task automatic send_request(t_mode mode, logic [ID_PORT_W-1:0] who,
                                logic [UNITS_W-1:0] n);
        int gap;
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_requester_id <= who;
        i_count        <= n;
        do @(posedge i_clk); while (o_in_stall);
        gap = (sender_calm || $urandom_range(0, 99) < 55) ? 0 : idle_span();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_directed();
        logic [ID_PORT_W-1:0] who;
        // requests on a closed semaphore, and close while closed
        send_request(MD_WAIT,   8'h11, 32'd1);
        send_request(MD_SIGNAL, 8'h22, 32'd5);
        send_request(MD_CLOSE,  8'h33, 32'd0);
        // open, zero-unit wait, block on the largest demand
        send_request(MD_OPEN,   8'h00, 32'd7);
        send_request(MD_WAIT,   8'h5a, 32'd0);
        send_request(MD_WAIT,   8'hff, 32'hffff_ffff);
        // overflowing signal saturates and wakes the head
        send_request(MD_SIGNAL, 8'h00, 32'hffff_ffff);
        send_request(MD_WAIT,   8'h00, 32'd1);
        // open with a waiter queued drops it
        send_request(MD_OPEN,   8'h44, 32'd3);
        // fill the queue, overflow it, then close with every waiter queued
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            who = 8'h01 << (k / 2);
            if (k % 2 == 1) who = ~who;
            send_request(MD_WAIT, who, (k == 0) ? 32'hffff_ffff : 32'(4 + k));
        end
        send_request(MD_WAIT,  8'h77, 32'd100);
        send_request(MD_CLOSE, 8'h88, 32'hffff_ffff);
    endtask

    task automatic run_random();
        int sent;
        int steps;
        int r;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            sender_calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                // noise word
                send_request(t_mode'($urandom_range(0, 3)), 8'($urandom), $urandom);
                sent += 1;
            end else if (r < 22) begin
                // pile waiters, at times past full, then release or close
                steps = $urandom_range(12, 19);
                send_request(MD_OPEN, 8'($urandom), $urandom_range(0, 8));
                repeat (steps) send_request(MD_WAIT, 8'($urandom), $urandom_range(9, 40));
                if ($urandom_range(0, 1) == 0)
                    send_request(MD_CLOSE, 8'($urandom), $urandom);
                else
                    send_request(MD_SIGNAL, 8'($urandom),
                                 ($urandom_range(0, 2) == 0) ? '1 : $urandom_range(20, 400));
                sent += steps + 2;
            end else begin
                // ordinary session of waits and signals
                steps = $urandom_range(3, 16);
                send_request(MD_OPEN, 8'($urandom), pick_units());
                repeat (steps) begin
                    r = $urandom_range(0, 99);
                    if (r < 50)
                        send_request(MD_WAIT, 8'($urandom), pick_units());
                    else if (r < 92)
                        send_request(MD_SIGNAL, 8'($urandom), pick_units());
                    else
                        send_request(MD_CLOSE, 8'($urandom), $urandom);
                end
                if ($urandom_range(0, 1) == 0)
                    send_request(MD_CLOSE, 8'($urandom), $urandom);
                sent += steps + 2;
            end
        end
        sender_calm = 1'b0;
    endtask

    // stimulus and end of run
    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("counting_semaphore_fifo_waiters verification clean");
        end else begin
            $display("counting_semaphore_fifo_waiters verification failed");
        end
        $finish;
    end

    // watchdog: too long with no word moving on either channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("counting_semaphore_fifo_waiters verification failed");
        $finish;
    end

endmodule
